// ----- design/dat_pkg.sv -----
// ----------------------------------------------------------------------------
// dat_pkg: device address table shared definitions
// Table size, field widths, operation and status codes, channel payload types
// and the control structs passed between the sequencer and the compare unit.
// ----------------------------------------------------------------------------
package dat_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // field widths
   localparam int FUNC_W   = 2;
   localparam int LONG_W   = 64;
   localparam int NET_W    = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 5;
   localparam int ENTRY_W  = LONG_W + NET_W;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_UPSERT      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP_LONG = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP_NET  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP         = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // one stored entry
   typedef struct packed {
      logic [LONG_W-1:0] long_addr;
      logic [NET_W-1:0]  net_addr;
   } entry_type;

   // request payload
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [LONG_W-1:0] long_addr;
      logic [NET_W-1:0]  net_addr;
   } req_type;

   // response payload
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [NET_W-1:0]    found_net_addr;
      logic [LONG_W-1:0]   found_long_addr;
   } rsp_type;

   // sequencer to compare unit
   typedef struct packed {
      logic             start;
      logic             check;
      logic             by_net;
      logic [IDX_W-1:0] idx;
   } cmp_ctl_type;

   // compare unit to sequencer
   typedef struct packed {
      logic             hit;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
   } cmp_sts_type;

   // low bits of an entry index as the slot field
   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// ----- design/dat_req_if.sv -----
// ----------------------------------------------------------------------------
// dat_req_if: request channel
// Valid/ready channel carrying one table operation.
// ----------------------------------------------------------------------------
interface dat_req_if
   import dat_pkg::*;
();

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [LONG_W-1:0] long_addr;
   logic [NET_W-1:0]  net_addr;

   modport source (output valid, output func, output long_addr, output net_addr,
                   input ready);
   modport sink   (input valid, input func, input long_addr, input net_addr,
                   output ready);

endinterface

// ----- design/dat_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dat_rsp_if: response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface dat_rsp_if
   import dat_pkg::*;
();

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [NET_W-1:0]    found_net_addr;
   logic [LONG_W-1:0]   found_long_addr;

   modport source (output valid, output status, output slot, output found_net_addr,
                   output found_long_addr, input ready);
   modport sink   (input valid, input status, input slot, input found_net_addr,
                   input found_long_addr, output ready);

endinterface

// ----- design/dat_ram.sv -----
// ----------------------------------------------------------------------------
// dat_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/dat_cmp.sv -----
// ----------------------------------------------------------------------------
// dat_cmp: shared entry compare unit
// Compares one stored entry per cycle against the request key and tracks the
// lowest free slot seen so far in the current scan.
// ----------------------------------------------------------------------------
module dat_cmp
   import dat_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmp_ctl_type      ctl,
   input  logic [LONG_W-1:0] key_long,
   input  logic [NET_W-1:0]  key_net,
   input  logic             entry_vld,
   input  entry_type        entry,
   output cmp_sts_type      sts
);

   logic             free_found_ff;
   logic             free_found_in;
   logic [IDX_W-1:0] free_idx_ff;
   logic [IDX_W-1:0] free_idx_in;
   logic             key_eq;
   logic             is_free;

   // key compare, long or short address
   assign key_eq  = ctl.by_net ? (entry.net_addr == key_net)
                               : (entry.long_addr == key_long);
   assign is_free = ctl.check && !entry_vld;

   // lowest free slot, including the entry under check this cycle
   always_comb begin
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (ctl.start) begin
         free_found_in = 1'b0;
      end else if (is_free && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = ctl.idx;
      end
   end

   always_comb begin
      sts.hit        = ctl.check && entry_vld && key_eq;
      sts.free_found = free_found_ff || is_free;
      sts.free_idx   = free_found_ff ? free_idx_ff : ctl.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_found_ff <= 1'b0;
      end else begin
         free_found_ff <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
   end

endmodule

// ----- design/device_address_table_core.sv -----
// ----------------------------------------------------------------------------
// device_address_table_core: long-to-short device address table
// Maps 64-bit long addresses to 16-bit short addresses with upsert, lookup by
// long address and lookup by short address.
// ----------------------------------------------------------------------------
// Usage
//   req_if carries one operation (func, long_addr, net_addr); it is taken when
//   valid and ready are both high. rsp_if returns exactly one result per
//   request (status, slot, found_net_addr, found_long_addr).
//   Each request is handled alone: ready is high only while no scan runs.
//   The entries sit in one RAM read one entry per cycle once the scan has
//   started, in ascending order, through a single compare unit; the scan
//   stops at the first match. A no-op code ends the scan without checking
//   any entry; a miss or insert checks every entry. The block is ready again
//   in the cycle after the result is loaded. The result waits in an output
//   register until rsp_if.ready; meanwhile the next request is taken and
//   held, and its scan starts once that register has been emptied.
//   Reset clears all valid bits at once; entry contents need no clearing, so
//   the block is ready as soon as reset drops.
// ----------------------------------------------------------------------------
module device_address_table_core
   import dat_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dat_req_if.sink   req_if,
   dat_rsp_if.source rsp_if
);

   state_type               state_ff;
   state_type               state_in;
   logic [CNT_W-1:0]        issue_ff;
   logic [CNT_W-1:0]        issue_in;
   logic                    chk_ff;
   logic                    chk_in;
   logic [IDX_W-1:0]        chk_idx_ff;
   logic [IDX_W-1:0]        chk_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;
   req_type                 req_ff;
   req_type                 req_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   logic                    accept;
   logic                    chk_last;
   logic                    scan_hold;
   logic                    scan_done;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [ENTRY_W-1:0]      rd_data;
   entry_type               rd_entry;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   entry_type               wr_entry;
   logic                    set_valid;
   cmp_ctl_type             cmp_ctl;
   cmp_sts_type             cmp_sts;

   assign accept   = req_if.valid && req_if.ready;
   assign rd_entry = entry_type'(rd_data);

   // entry store
   dat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared compare unit
   always_comb begin
      cmp_ctl.start  = accept;
      cmp_ctl.check  = chk_ff;
      cmp_ctl.by_net = (req_ff.func == FUNC_LOOKUP_NET);
      cmp_ctl.idx    = chk_idx_ff;
   end

   dat_cmp u_cmp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cmp_ctl),
      .key_long  (req_ff.long_addr),
      .key_net   (req_ff.net_addr),
      .entry_vld (valid_ff[chk_idx_ff]),
      .entry     (rd_entry),
      .sts       (cmp_sts)
   );

   // scan start waits while the previous result is still in the output register
   assign scan_hold = (state_ff == ST_SCAN) && !chk_ff && (issue_ff == '0)
                      && rsp_valid_ff;

   // end of scan: match, last entry checked, or no-op code
   assign chk_last  = chk_ff && (chk_idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign scan_done = (state_ff == ST_SCAN) && !scan_hold
                      && ((req_ff.func == FUNC_NOP) || cmp_sts.hit || chk_last);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and result selection
   always_comb begin
      issue_in   = issue_ff;
      chk_in     = 1'b0;
      chk_idx_in = chk_idx_ff;
      req_in     = req_ff;
      rsp_in     = rsp_ff;
      rd_en      = 1'b0;
      rd_addr    = issue_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = chk_idx_ff;
      wr_entry   = '{long_addr: rd_entry.long_addr, net_addr: req_ff.net_addr};
      set_valid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in.func      = req_if.func;
               req_in.long_addr = req_if.long_addr;
               req_in.net_addr  = req_if.net_addr;
               issue_in         = '0;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               rsp_in = '{status: STATUS_NOT_FOUND, slot: '0, found_net_addr: '0,
                          found_long_addr: '0};
               if (req_ff.func == FUNC_NOP) begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end else if (cmp_sts.hit) begin
                  rsp_in.status          = STATUS_OK;
                  rsp_in.slot            = to_slot(chk_idx_ff);
                  rsp_in.found_long_addr = rd_entry.long_addr;
                  rsp_in.found_net_addr  = rd_entry.net_addr;
                  // upsert of a known address rewrites its short address
                  if (req_ff.func == FUNC_UPSERT) begin
                     wr_en                 = 1'b1;
                     rsp_in.found_net_addr = req_ff.net_addr;
                  end
               end else if (req_ff.func == FUNC_UPSERT) begin
                  if (cmp_sts.free_found) begin
                     // insert into lowest free slot
                     wr_en                  = 1'b1;
                     set_valid              = 1'b1;
                     wr_addr                = cmp_sts.free_idx;
                     wr_entry               = '{long_addr: req_ff.long_addr,
                                                net_addr: req_ff.net_addr};
                     rsp_in.status          = STATUS_OK;
                     rsp_in.slot            = to_slot(cmp_sts.free_idx);
                     rsp_in.found_long_addr = req_ff.long_addr;
                     rsp_in.found_net_addr  = req_ff.net_addr;
                  end else begin
                     rsp_in.status = STATUS_FULL;
                  end
               end
            end else if (!scan_hold && (issue_ff < CNT_W'(TABLE_ENTRIES))) begin
               // issue next entry read, checked in the following cycle
               rd_en      = 1'b1;
               issue_in   = issue_ff + CNT_W'(1);
               chk_in     = 1'b1;
               chk_idx_in = issue_ff[IDX_W-1:0];
            end
         end
         default: begin
            chk_in = 1'b0;
         end
      endcase
   end

   // output register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (scan_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   // valid bits, set on insert only
   always_comb begin
      valid_in = valid_ff;
      if (set_valid) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
   end

   // channel outputs
   assign req_if.ready           = (state_ff == ST_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_ff.status;
   assign rsp_if.slot            = rsp_ff.slot;
   assign rsp_if.found_net_addr  = rsp_ff.found_net_addr;
   assign rsp_if.found_long_addr = rsp_ff.found_long_addr;

   // read pointer stays within the table during a scan
   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_ff <= CNT_W'(TABLE_ENTRIES)))
      else $error("scan read pointer past table end");

   // checked entry is always the one read in the previous cycle
   a_chk_lag: assert property (@(posedge clock) disable iff (reset)
      chk_ff |-> (issue_ff == CNT_W'(chk_idx_ff) + CNT_W'(1)))
      else $error("compare index out of step with read pointer");

   // the table is written only when an upsert finishes
   a_write_upsert: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (scan_done && (req_ff.func == FUNC_UPSERT)))
      else $error("table written outside an upsert");

   // full is reported only when every slot is taken
   a_full_valid: assert property (@(posedge clock) disable iff (reset)
      (scan_done && (rsp_in.status == STATUS_FULL)) |-> (&valid_ff))
      else $error("table full reported with a free slot");

   // short lookups and upserts return the request short address
   a_net_echo: assert property (@(posedge clock) disable iff (reset)
      (scan_done && (rsp_in.status == STATUS_OK)
       && (req_ff.func != FUNC_LOOKUP_LONG))
      |-> (rsp_in.found_net_addr == req_ff.net_addr))
      else $error("short address in response differs from request");

endmodule

// ----- test/device_address_table_checker.sv -----
// ----------------------------------------------------------------------------
// device_address_table_checker: request/response scoreboard for the table
// Watches both channels, keeps its own copy of the address table, works out
// the response due for each accepted request and compares every accepted
// response field by field against the oldest one due.
// ----------------------------------------------------------------------------
module device_address_table_checker
   import dat_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dat_req_if   req_if,
   dat_rsp_if   rsp_if,
   output int   errors,
   output int   outstanding
);

   // shadow copy of the table
   logic              shadow_valid [TABLE_ENTRIES];
   logic [LONG_W-1:0] shadow_long  [TABLE_ENTRIES];
   logic [NET_W-1:0]  shadow_net   [TABLE_ENTRIES];

   rsp_type rsp_due [$];
   rsp_type head_rsp;
   int      mismatch_count = 0;

   initial begin
      errors      = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // apply one operation to the shadow table and return its response
   function automatic rsp_type table_op(input logic [FUNC_W-1:0] func,
                                        input logic [LONG_W-1:0] key_long,
                                        input logic [NET_W-1:0]  key_net);
      rsp_type r;
      int      hit;
      int      vacant;
      r      = '0;
      hit    = -1;
      vacant = -1;
      // lowest valid match on the key of this operation
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit < 0 && shadow_valid[i]) begin
            if ((func == FUNC_UPSERT || func == FUNC_LOOKUP_LONG) &&
                shadow_long[i] == key_long)
               hit = i;
            else if (func == FUNC_LOOKUP_NET && shadow_net[i] == key_net)
               hit = i;
         end
      end
      // new long address claims the lowest free entry
      if (func == FUNC_UPSERT && hit < 0) begin
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (vacant < 0 && !shadow_valid[i])
               vacant = i;
         if (vacant >= 0) begin
            shadow_valid[vacant] = 1'b1;
            shadow_long[vacant]  = key_long;
            hit                  = vacant;
         end
      end
      if (func == FUNC_UPSERT && hit >= 0)
         shadow_net[hit] = key_net;
      if (hit >= 0) begin
         r.status          = STATUS_OK;
         r.slot            = hit[SLOT_W-1:0];
         r.found_net_addr  = shadow_net[hit];
         r.found_long_addr = shadow_long[hit];
      end else begin
         r.status = (func == FUNC_UPSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
      end
      return r;
   endfunction

   // compare responses, then record the request taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_long[i]  = '0;
            shadow_net[i]   = '0;
         end
         rsp_due.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (rsp_due.size() == 0) begin
               report_mismatch("unexpected response, status", 64'(rsp_if.status), '0);
            end else begin
               head_rsp = rsp_due.pop_front();
               if (rsp_if.status !== head_rsp.status)
                  report_mismatch("status", 64'(rsp_if.status), 64'(head_rsp.status));
               if (rsp_if.slot !== head_rsp.slot)
                  report_mismatch("slot", 64'(rsp_if.slot), 64'(head_rsp.slot));
               if (rsp_if.found_net_addr !== head_rsp.found_net_addr)
                  report_mismatch("found_net_addr", 64'(rsp_if.found_net_addr),
                                  64'(head_rsp.found_net_addr));
               if (rsp_if.found_long_addr !== head_rsp.found_long_addr)
                  report_mismatch("found_long_addr", rsp_if.found_long_addr,
                                  head_rsp.found_long_addr);
            end
         end
         if (req_if.valid && req_if.ready)
            rsp_due.push_back(table_op(req_if.func, req_if.long_addr, req_if.net_addr));
      end
      outstanding <= rsp_due.size();
      errors      <= mismatch_count;
   end

endmodule

// ----- test/device_address_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// device_address_table_core_tb: stimulus and verdict for the address table
// Runs a short directed sequence over empty-table misses, inserts, updates,
// duplicate short addresses and no-op codes, then random bursts of upserts,
// lookups and no-op codes that fill the table and keep hitting it once
// full. The receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module device_address_table_core_tb;
   import dat_pkg::*;

   localparam int RANDOM_REQUESTS = 1750;
   localparam int LONG_HOLD       = 300;
   localparam int HOLD_AFTER      = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 1000000;

   logic clock;
   logic reset;
   int   errors;
   int   outstanding;
   int   rsp_taken = 0;
   int   cycles    = 0;

   // keys and short addresses already offered, reused to hit the table
   logic [LONG_W-1:0] known_longs [$];
   logic [NET_W-1:0]  used_nets   [$];
   logic [NET_W-1:0]  net_pool    [4] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'h0001};

   dat_req_if req_if();
   dat_rsp_if rsp_if();

   device_address_table_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   device_address_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .errors      (errors),
      .outstanding (outstanding)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // responses taken so far, used to place the long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         rsp_taken <= rsp_taken + 1;
   end

   // receiver: random stall patterns, full-rate stretches, one long hold-off
   initial begin : rsp_side
      logic [15:0] pattern;
      int unsigned run_len;
      bit          held_off;
      held_off = 1'b0;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (!held_off && rsp_taken >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         pattern = 16'($urandom);
         if ($urandom_range(3, 0) == 0)
            pattern = '1;
         run_len = $urandom_range(64, 8);
         for (int k = 0; k < run_len; k++) begin
            rsp_if.ready <= pattern[k % 16];
            @(posedge clock);
         end
      end
   end

   // offer one request and hold it until taken
   task automatic issue_request(input logic [FUNC_W-1:0] func,
                                input logic [LONG_W-1:0] long_addr,
                                input logic [NET_W-1:0]  net_addr);
      req_if.valid     <= 1'b1;
      req_if.func      <= func;
      req_if.long_addr <= long_addr;
      req_if.net_addr  <= net_addr;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // short address: often from a small pool so that duplicates occur
   function automatic logic [NET_W-1:0] pick_net();
      logic [NET_W-1:0] net_val;
      if ($urandom_range(1, 0) == 0)
         net_val = net_pool[$urandom_range(3, 0)];
      else
         net_val = NET_W'($urandom);
      used_nets.push_back(net_val);
      return net_val;
   endfunction

   // one random request, weighted toward hits on known entries
   task automatic random_request();
      int unsigned       pick;
      logic [LONG_W-1:0] key;
      logic [NET_W-1:0]  net_val;
      pick    = $urandom_range(99, 0);
      key     = {$urandom, $urandom};
      net_val = NET_W'($urandom);
      if (pick < 6) begin
         // new long address: insert, or table full once all entries are taken
         net_val = pick_net();
         known_longs.push_back(key);
         issue_request(FUNC_UPSERT, key, net_val);
      end else if (pick < 36) begin
         // update of a known long address
         key     = known_longs[$urandom_range(known_longs.size() - 1, 0)];
         net_val = pick_net();
         issue_request(FUNC_UPSERT, key, net_val);
      end else if (pick < 61) begin
         // long lookup: known key, one-bit near miss, or random
         case ($urandom_range(5, 0))
            0: ;
            1: key = known_longs[$urandom_range(known_longs.size() - 1, 0)] ^
                     (64'd1 << $urandom_range(LONG_W - 1, 0));
            default: key = known_longs[$urandom_range(known_longs.size() - 1, 0)];
         endcase
         issue_request(FUNC_LOOKUP_LONG, key, net_val);
      end else if (pick < 91) begin
         // short lookup: mostly a short address seen before
         if ($urandom_range(9, 0) < 6)
            net_val = used_nets[$urandom_range(used_nets.size() - 1, 0)];
         issue_request(FUNC_LOOKUP_NET, key, net_val);
      end else begin
         issue_request(FUNC_NOP, key, net_val);
      end
   endtask

   // reset, directed sequence, random bursts, drain and verdict
   initial begin : req_side
      int          sent;
      int unsigned burst;
      int unsigned gap;
      bit          paused;
      paused = 1'b0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.func      <= FUNC_UPSERT;
      req_if.long_addr <= '0;
      req_if.net_addr  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // misses on the empty table
      issue_request(FUNC_LOOKUP_LONG, 64'h0, 16'h0000);
      issue_request(FUNC_LOOKUP_NET, 64'h0, 16'h0000);
      // inserts at both extremes
      issue_request(FUNC_UPSERT, 64'h0, 16'h0000);
      issue_request(FUNC_UPSERT, '1, 16'hFFFF);
      issue_request(FUNC_LOOKUP_LONG, '1, 16'h0000);
      issue_request(FUNC_LOOKUP_NET, 64'h0, 16'hFFFF);
      // update of a known long address, old short address gone
      issue_request(FUNC_UPSERT, 64'h0, 16'hA5A5);
      issue_request(FUNC_LOOKUP_NET, '1, 16'h0000);
      issue_request(FUNC_LOOKUP_LONG, 64'h0, 16'h0000);
      // duplicate short address resolves to the lowest entry
      issue_request(FUNC_UPSERT, 64'h8000_0000_0000_0001, 16'hFFFF);
      issue_request(FUNC_LOOKUP_NET, 64'h0, 16'hFFFF);
      issue_request(FUNC_LOOKUP_LONG, 64'h8000_0000_0000_0000, 16'hFFFF);
      // no-op code with extreme fields
      issue_request(FUNC_NOP, '1, 16'hFFFF);
      issue_request(FUNC_NOP, 64'h0, 16'h0000);
      // move the lower duplicate away, the higher one now matches
      issue_request(FUNC_UPSERT, '1, 16'h0000);
      issue_request(FUNC_LOOKUP_NET, '1, 16'hFFFF);
      issue_request(FUNC_LOOKUP_LONG, 64'h8000_0000_0000_0001, 16'h0000);
      known_longs = '{64'h0, '1, 64'h8000_0000_0000_0001};
      used_nets   = '{16'h0000, 16'hFFFF, 16'hA5A5};

      // random bursts with gaps, one pause until all responses are back
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(24, 1);
         for (int b = 0; b < burst && sent < RANDOM_REQUESTS; b++) begin
            random_request();
            sent++;
         end
         gap = ($urandom_range(2, 0) == 0) ? $urandom_range(20, 1) : 0;
         if (!paused && sent >= RANDOM_REQUESTS / 2) begin
            paused = 1'b1;
            req_if.valid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end else if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      // drain
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/dat_pkg.sv
design/dat_req_if.sv
design/dat_rsp_if.sv
design/dat_ram.sv
design/dat_cmp.sv
design/device_address_table_core.sv
test/device_address_table_checker.sv
test/device_address_table_core_tb.sv
